// ----- hw/rtl/hsv_hsl_to_rgb_converter_defines.svh -----
// Assertion macros used by the HSV/HSL to RGB converter top level.
`ifndef HSV_HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_HSL_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSXRGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSXRGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- hw/rtl/hsxrgb_pkg.sv -----
// Types and constants of the HSV/HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsxrgb_pkg;

    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned CH_W      = 13;
    localparam int unsigned ONE_INT   = 1 << FRAC_BITS;
    localparam logic [CH_W-1:0] ONE   = ONE_INT[CH_W-1:0];

    // Hue in 1/16 degree: 360 degrees and one 60 degree sector.
    localparam int unsigned HUE_W      = 16;
    localparam int unsigned HUE_FULL   = 5760;
    localparam int unsigned HUE_SECTOR = 960;
    localparam int unsigned HREM_W     = 13;
    localparam int unsigned RAMP_W     = 10;
    localparam int unsigned PROD_W     = CH_W + RAMP_W;

    // x = prod / 960 = (prod >> 6) / 15, the latter as a multiply by
    // ceil(2^19 / 15); exact for every quotient input below 2^19 / 7.
    localparam int unsigned DIV_PRE_SHIFT = 6;
    localparam int unsigned QIN_W         = 16;
    localparam int unsigned RECIP_SHIFT   = 19;
    localparam logic [QIN_W-1:0] RECIP_15 = 16'd34953;

    localparam int unsigned PADDR_W = 3;
    localparam logic REG_IDX_COLOR_MODEL = 1'b0;

    typedef enum logic {
        MODEL_HSV = 1'b0,
        MODEL_HSL = 1'b1
    } t_color_model;

    // Sector names: channel at full chroma, then channel carrying x.
    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } t_hue_sector;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [CH_W-1:0]         saturation;
        logic [CH_W-1:0]         level;
    } t_hsx_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_rsp;

    // Per-request values handed from the hue/chroma half to the channel half.
    typedef struct packed {
        logic [CH_W-1:0]   chroma;
        logic [CH_W-1:0]   offset;
        logic [RAMP_W-1:0] ramp;
        t_hue_sector       sector;
    } t_hsx_mid;

endpackage

`default_nettype wire

// ----- hw/rtl/hsxrgb_cfg.sv -----
// APB register file holding the color model select.
`timescale 1ns / 1ps
`default_nettype none

module hsxrgb_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hsxrgb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    output hsxrgb_pkg::t_color_model               o_model
);

    hsxrgb_pkg::t_color_model r_model;
    logic                     reg_hit;

    assign reg_hit = (paddr[hsxrgb_pkg::PADDR_W-1] == hsxrgb_pkg::REG_IDX_COLOR_MODEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= hsxrgb_pkg::MODEL_HSV;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_model <= hsxrgb_pkg::t_color_model'(pwdata[0]);
        end
    end

    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {31'd0, r_model} : 32'd0;
    assign o_model = r_model;

endmodule

`default_nettype wire

// ----- hw/rtl/hsxrgb_front.sv -----
// Front half: hue reduction, chroma multiply, sector, ramp and offset.
`timescale 1ns / 1ps
`default_nettype none

module hsxrgb_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire hsxrgb_pkg::t_hsx_req     i_req,
    input  wire hsxrgb_pkg::t_color_model i_model,
    output logic                          o_valid,
    output hsxrgb_pkg::t_hsx_mid          o_mid
);

    localparam int unsigned CW = hsxrgb_pkg::CH_W;
    localparam int unsigned HW = hsxrgb_pkg::HUE_W;
    localparam int unsigned RW = hsxrgb_pkg::HREM_W;
    localparam int unsigned FB = hsxrgb_pkg::FRAC_BITS;
    localparam int unsigned SEC = hsxrgb_pkg::HUE_SECTOR;
    localparam int unsigned TW = RW - 2;
    localparam int unsigned AW = hsxrgb_pkg::RAMP_W;

    // stage 1: absolute hue, clamped saturation and level
    logic                     r1_valid;
    logic [HW-1:0]            r1_habs;
    logic [CW-1:0]            r1_sat;
    logic [CW-1:0]            r1_lvl;
    hsxrgb_pkg::t_color_model r1_model;
    logic [HW-1:0]            hue_u;
    logic [HW-1:0]            n_habs;
    logic [CW-1:0]            n_sat;
    logic [CW-1:0]            n_lvl;

    // stage 2: hue mod 360 degrees and chroma
    logic                     r2_valid;
    logic [RW-1:0]            r2_hrem;
    logic [CW-1:0]            r2_chroma;
    logic [CW-1:0]            r2_lvl;
    hsxrgb_pkg::t_color_model r2_model;
    logic [HW-1:0]            n_hrem;
    logic [CW:0]              twol;
    logic [CW:0]              span;
    logic [CW-1:0]            factor;
    logic [2*CW-1:0]          cprod;

    // stage 3: sector, ramp and offset
    logic                     r3_valid;
    hsxrgb_pkg::t_hsx_mid     r3_mid;
    hsxrgb_pkg::t_hsx_mid     n_mid;
    logic [TW-1:0]            t_pos;

    assign hue_u  = i_req.hue;
    assign n_habs = hue_u[HW-1] ? (~hue_u + HW'(1)) : hue_u;
    assign n_sat  = (i_req.saturation > hsxrgb_pkg::ONE) ? hsxrgb_pkg::ONE : i_req.saturation;
    assign n_lvl  = (i_req.level > hsxrgb_pkg::ONE) ? hsxrgb_pkg::ONE : i_req.level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_habs  <= n_habs;
        r1_sat   <= n_sat;
        r1_lvl   <= n_lvl;
        r1_model <= i_model;
    end

    // The largest multiple of 360 degrees not above the hue wins.
    always_comb begin
        n_hrem = r1_habs;
        for (int k = 1; k <= 5; k++) begin
            if (r1_habs >= HW'(k * hsxrgb_pkg::HUE_FULL)) begin
                n_hrem = r1_habs - HW'(k * hsxrgb_pkg::HUE_FULL);
            end
        end
    end

    // HSL span = 1 - |2L - 1|
    assign twol   = {r1_lvl, 1'b0};
    assign span   = (twol >= (CW+1)'(hsxrgb_pkg::ONE_INT))
                    ? ((CW+1)'(2 * hsxrgb_pkg::ONE_INT) - twol) : twol;
    assign factor = (r1_model == hsxrgb_pkg::MODEL_HSL) ? span[CW-1:0] : r1_lvl;
    assign cprod  = (2*CW)'(factor) * (2*CW)'(r1_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hrem   <= n_hrem[RW-1:0];
        r2_chroma <= cprod[FB+CW-1:FB];
        r2_lvl    <= r1_lvl;
        r2_model  <= r1_model;
    end

    always_comb begin
        n_mid = '0;
        if (r2_hrem < RW'(SEC)) begin
            n_mid.sector = hsxrgb_pkg::SEC_RED_GREEN;
        end else if (r2_hrem < RW'(2 * SEC)) begin
            n_mid.sector = hsxrgb_pkg::SEC_GREEN_RED;
        end else if (r2_hrem < RW'(3 * SEC)) begin
            n_mid.sector = hsxrgb_pkg::SEC_GREEN_BLUE;
        end else if (r2_hrem < RW'(4 * SEC)) begin
            n_mid.sector = hsxrgb_pkg::SEC_BLUE_GREEN;
        end else if (r2_hrem < RW'(5 * SEC)) begin
            n_mid.sector = hsxrgb_pkg::SEC_BLUE_RED;
        end else begin
            n_mid.sector = hsxrgb_pkg::SEC_RED_BLUE;
        end

        // position within the 120 degree pair of sectors
        if (r2_hrem >= RW'(4 * SEC)) begin
            t_pos = TW'(r2_hrem - RW'(4 * SEC));
        end else if (r2_hrem >= RW'(2 * SEC)) begin
            t_pos = TW'(r2_hrem - RW'(2 * SEC));
        end else begin
            t_pos = TW'(r2_hrem);
        end

        // ramp = 960 - |t - 960|
        if (t_pos >= TW'(SEC)) begin
            n_mid.ramp = AW'(TW'(2 * SEC) - t_pos);
        end else begin
            n_mid.ramp = AW'(t_pos);
        end

        n_mid.chroma = r2_chroma;
        if (r2_model == hsxrgb_pkg::MODEL_HSL) begin
            n_mid.offset = r2_lvl - (r2_chroma >> 1);
        end else begin
            n_mid.offset = r2_lvl - r2_chroma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_mid <= n_mid;
    end

    assign o_valid = r3_valid;
    assign o_mid   = r3_mid;

endmodule

`default_nettype wire

// ----- hw/rtl/hsxrgb_back.sv -----
// Back half: x = chroma * ramp / 960, sector routing and offset add.
`timescale 1ns / 1ps
`default_nettype none

module hsxrgb_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire hsxrgb_pkg::t_hsx_mid i_mid,
    output logic                      o_valid,
    output hsxrgb_pkg::t_rgb_rsp      o_rsp
);

    localparam int unsigned CW = hsxrgb_pkg::CH_W;
    localparam int unsigned PW = hsxrgb_pkg::PROD_W;
    localparam int unsigned QW = hsxrgb_pkg::QIN_W;
    localparam int unsigned PS = hsxrgb_pkg::DIV_PRE_SHIFT;
    localparam int unsigned RS = hsxrgb_pkg::RECIP_SHIFT;

    // stage 4: chroma * ramp
    logic                 r4_valid;
    hsxrgb_pkg::t_hsx_mid r4_mid;
    logic [PW-1:0]        r4_prod;
    logic [PW-1:0]        n_prod;

    // stage 5: divide by 960
    logic                 r5_valid;
    hsxrgb_pkg::t_hsx_mid r5_mid;
    logic [CW-1:0]        r5_x;
    logic [QW-1:0]        q_in;
    logic [2*QW-1:0]      q_prod;

    // stage 6: output
    logic                 r6_valid;
    hsxrgb_pkg::t_rgb_rsp r6_rsp;
    hsxrgb_pkg::t_rgb_rsp n_rsp;
    logic [CW-1:0]        red_b;
    logic [CW-1:0]        green_b;
    logic [CW-1:0]        blue_b;

    assign n_prod = PW'(i_mid.chroma) * PW'(i_mid.ramp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_mid  <= i_mid;
        r4_prod <= n_prod;
    end

    assign q_in   = r4_prod[PS+QW-1:PS];
    assign q_prod = (2*QW)'(q_in) * (2*QW)'(hsxrgb_pkg::RECIP_15);

    always_ff @(posedge i_clk) begin
        r5_mid <= r4_mid;
        r5_x   <= q_prod[RS+CW-1:RS];
    end

    always_comb begin
        red_b   = '0;
        green_b = '0;
        blue_b  = '0;
        case (r5_mid.sector)
            hsxrgb_pkg::SEC_RED_GREEN: begin
                red_b   = r5_mid.chroma;
                green_b = r5_x;
            end
            hsxrgb_pkg::SEC_GREEN_RED: begin
                red_b   = r5_x;
                green_b = r5_mid.chroma;
            end
            hsxrgb_pkg::SEC_GREEN_BLUE: begin
                green_b = r5_mid.chroma;
                blue_b  = r5_x;
            end
            hsxrgb_pkg::SEC_BLUE_GREEN: begin
                green_b = r5_x;
                blue_b  = r5_mid.chroma;
            end
            hsxrgb_pkg::SEC_BLUE_RED: begin
                red_b   = r5_x;
                blue_b  = r5_mid.chroma;
            end
            default: begin
                red_b   = r5_mid.chroma;
                blue_b  = r5_x;
            end
        endcase
        n_rsp.red   = red_b + r5_mid.offset;
        n_rsp.green = green_b + r5_mid.offset;
        n_rsp.blue  = blue_b + r5_mid.offset;
    end

    always_ff @(posedge i_clk) begin
        r6_rsp <= n_rsp;
    end

    assign o_valid = r6_valid;
    assign o_rsp   = r6_rsp;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_hsl_to_rgb_converter.sv -----
// HSV/HSL to RGB converter top level: register port and six-stage pipeline.
// o_strobe marks each result as it leaves the last stage register.
// Throughput: one request per cycle; busy stays low and results are never held off.
// The chroma multiply, the ramp multiply and the reciprocal multiply for the
// divide by 960 are each followed by a register.
// Reset (synchronous, active low) clears all valid bits and selects HSV.
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_hsl_to_rgb_converter_defines.svh"

module hsv_hsl_to_rgb_converter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire hsxrgb_pkg::t_hsx_req           i_req,
    output logic                                o_strobe,
    output hsxrgb_pkg::t_rgb_rsp                o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hsxrgb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    hsxrgb_pkg::t_color_model model;
    hsxrgb_pkg::t_hsx_mid     mid;
    logic                     mid_valid;

    assign busy = 1'b0;

    hsxrgb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_model (model)
    );

    hsxrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .i_model (model),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    hsxrgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_valid (o_strobe),
        .o_rsp   (o_rsp)
    );

    `HSXRGB_ASSERT_IMP(a_latency, i_clk, i_rst_n, start && !busy, ##6 o_strobe, "request lost in pipeline")
    `HSXRGB_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, o_strobe, $past(start && !busy, 6), "result without request")
    `HSXRGB_ASSERT_IMP(a_range, i_clk, i_rst_n, o_strobe, (o_rsp.red <= hsxrgb_pkg::ONE && o_rsp.green <= hsxrgb_pkg::ONE && o_rsp.blue <= hsxrgb_pkg::ONE), "channel above 1.0")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the HSV/HSL to RGB converter.
`timescale 1ns / 1ps

module testbench;
    import hsxrgb_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_COLOR_MODEL = PADDR_W'(4 * REG_IDX_COLOR_MODEL);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED      = PADDR_W'(4);
    localparam int unsigned        DRAIN_LIMIT      = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_hsx_req             req_drv;
    logic                 o_strobe;
    t_rgb_rsp             o_rsp;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    t_color_model active_model;
    t_rgb_rsp     pending_rgb[$];
    int unsigned  mismatches;

    hsv_hsl_to_rgb_converter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req_drv),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("testbench: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_rgb_rsp rgb_from_hsx(input t_hsx_req req, input t_color_model model);
        int unsigned       hraw;
        int unsigned       habs;
        int unsigned       hrem;
        int unsigned       tpos;
        int unsigned       fold;
        int unsigned       ramp_pos;
        longint unsigned   sat;
        longint unsigned   lvl;
        longint unsigned   span;
        longint unsigned   chroma;
        longint unsigned   ramp_val;
        longint unsigned   offs;
        longint unsigned   red;
        longint unsigned   green;
        longint unsigned   blue;
        t_hue_sector       sector;
        t_rgb_rsp          rsp;
        hraw = 32'(req.hue[HUE_W-1:0]);
        // mirror negative hues onto their positive twin
        habs = req.hue[HUE_W-1] ? (32'h10000 - hraw) : hraw;
        hrem = habs % HUE_FULL;
        sector = t_hue_sector'(3'(hrem / HUE_SECTOR));
        tpos = hrem % (2 * HUE_SECTOR);
        fold = (tpos >= HUE_SECTOR) ? (tpos - HUE_SECTOR) : (HUE_SECTOR - tpos);
        ramp_pos = HUE_SECTOR - fold;
        sat = (req.saturation > ONE_INT) ? ONE_INT : req.saturation;
        lvl = (req.level > ONE_INT) ? ONE_INT : req.level;
        if (model == MODEL_HSV) begin
            chroma = (lvl * sat) >> FRAC_BITS;
            offs = lvl - chroma;
        end else begin
            span = (2 * lvl >= ONE_INT) ? (2 * ONE_INT - 2 * lvl) : 2 * lvl;
            chroma = (span * sat) >> FRAC_BITS;
            offs = lvl - (chroma >> 1);
        end
        ramp_val = (chroma * ramp_pos) / HUE_SECTOR;
        red = 0;
        green = 0;
        blue = 0;
        case (sector)
            SEC_RED_GREEN: begin
                red = chroma;
                green = ramp_val;
            end
            SEC_GREEN_RED: begin
                red = ramp_val;
                green = chroma;
            end
            SEC_GREEN_BLUE: begin
                green = chroma;
                blue = ramp_val;
            end
            SEC_BLUE_GREEN: begin
                green = ramp_val;
                blue = chroma;
            end
            SEC_BLUE_RED: begin
                red = ramp_val;
                blue = chroma;
            end
            default: begin
                red = chroma;
                blue = ramp_val;
            end
        endcase
        rsp.red = CH_W'(red + offs);
        rsp.green = CH_W'(green + offs);
        rsp.blue = CH_W'(blue + offs);
        return rsp;
    endfunction

    // Results can't be held off: take every strobe at the edge ending it.
    always @(posedge i_clk) begin : rgb_check
        t_rgb_rsp want;
        if (i_rst_n && o_strobe) begin
            if (pending_rgb.size() == 0) begin
                report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                          o_rsp.red, o_rsp.green, o_rsp.blue));
            end else begin
                want = pending_rgb.pop_front();
                if (o_rsp.red !== want.red)
                    report_mismatch($sformatf("red got %0d exp %0d", o_rsp.red, want.red));
                if (o_rsp.green !== want.green)
                    report_mismatch($sformatf("green got %0d exp %0d",
                                              o_rsp.green, want.green));
                if (o_rsp.blue !== want.blue)
                    report_mismatch($sformatf("blue got %0d exp %0d", o_rsp.blue, want.blue));
            end
        end
    end

    // Leave start high so back-to-back requests stay back to back.
    task automatic send_request(input t_hsx_req req);
        @(negedge i_clk);
        start <= 1'b1;
        req_drv <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_rgb.push_back(rgb_from_hsx(req, active_model));
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results;
        int unsigned waited;
        idle_cycles(1);
        waited = 0;
        while (pending_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (pending_rgb.size() != 0) begin
            void'(pending_rgb.pop_front());
            report_mismatch("expected result never arrived");
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_COLOR_MODEL)
            active_model = t_color_model'(data[0]);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check_model;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_COLOR_MODEL;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(active_model))
            report_mismatch($sformatf("color_model read %0h exp %0h", prdata, active_model));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] rand_unit;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE;
            2: return CH_W'($urandom_range(ONE_INT + 1, (1 << CH_W) - 1));
            default: return CH_W'($urandom_range(0, ONE_INT));
        endcase
    endfunction

    function automatic t_hsx_req rand_request;
        t_hsx_req req;
        int       base;
        case ($urandom_range(0, 4))
            0, 1, 2: req.hue = HUE_W'($urandom());
            3: req.hue = HUE_W'($urandom_range(0, HUE_FULL - 1));
            default: begin
                // land on or next to a sector boundary, either sign
                base = $urandom_range(0, 34) * HUE_SECTOR + $urandom_range(0, 4) - 2;
                req.hue = HUE_W'($urandom_range(0, 1) ? -base : base);
            end
        endcase
        req.saturation = rand_unit();
        req.level = rand_unit();
        return req;
    endfunction

    task automatic test_reset_state;
        t_hsx_req req;
        apb_check_model();
        req.hue = HUE_W'(1500);
        req.saturation = CH_W'(3000);
        req.level = CH_W'(2500);
        send_request(req);
        drain_results();
    endtask

    task automatic test_register;
        t_hsx_req req;
        // stray address: must not move the model
        apb_write(ADDR_UNUSED, 32'h0000_0001);
        apb_check_model();
        apb_write(ADDR_COLOR_MODEL, 32'hFFFF_FFFF);
        apb_check_model();
        req = rand_request();
        send_request(req);
        drain_results();
        apb_write(ADDR_UNUSED, 32'h0000_0000);
        apb_check_model();
        apb_write(ADDR_COLOR_MODEL, 32'hFFFF_FFFE);
        apb_check_model();
        send_request(req);
        drain_results();
    endtask

    task automatic test_directed;
        t_hsx_req    list[12];
        int          hues[12];
        int unsigned sats[12];
        int unsigned lvls[12];
        hues = '{0, 32767, -32768, -1, 5759, 5760, -5760, 959, 2880, 4800, 100, -100};
        sats = '{4096, 4096, 8191, 0, 4096, 2048, 4095, 4096, 8191, 1, 3000, 3000};
        lvls = '{4096, 2048, 8191, 4096, 0, 4096, 2048, 2049, 1024, 4096, 3500, 3500};
        for (int i = 0; i < 12; i++) begin
            list[i].hue = HUE_W'(hues[i]);
            list[i].saturation = CH_W'(sats[i]);
            list[i].level = CH_W'(lvls[i]);
        end
        for (int m = 0; m < 2; m++) begin
            apb_write(ADDR_COLOR_MODEL, 32'(m));
            foreach (list[i]) send_request(list[i]);
            drain_results();
        end
    endtask

    task automatic test_random(input int unsigned total);
        int unsigned per_phase;
        int unsigned sent;
        int unsigned burst;
        logic [31:0] wval;
        per_phase = total / 8;
        for (int phase = 0; phase < 8; phase++) begin
            wval = ($urandom() & 32'hFFFF_FFFE) | 32'(phase % 2);
            apb_write(ADDR_COLOR_MODEL, wval);
            sent = 0;
            while (sent < per_phase) begin
                burst = $urandom_range(1, 32);
                for (int k = 0; k < burst && sent < per_phase; k++) begin
                    send_request(rand_request());
                    sent++;
                end
                // phase three streams without gaps
                if (phase != 3 && $urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 7));
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        req_drv = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        active_model = MODEL_HSV;
        mismatches = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_register();
        test_directed();
        test_random(800);
        drain_results();
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
